// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ceha_pkg.sv =====
// ---------------------------------------------------------------------------
// ceha_pkg
// Types and constants shared by the crash event hold alarm modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ceha_pkg;

    localparam int unsigned HOLD_W  = 32;
    localparam int unsigned THR_W   = 15;
    localparam int unsigned VOTE_W  = 3;
    localparam int unsigned ACCEL_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOTE_MIN       = 2'd2;

    // Register reset values (tilt threshold is 0.6 g at 16384 counts per g)
    localparam logic [HOLD_W-1:0] HOLD_MS_RST        = 32'd10000;
    localparam logic [THR_W-1:0]  TILT_THRESHOLD_RST = 15'd9830;
    localparam logic [VOTE_W-1:0] VOTE_MIN_RST       = 3'd3;

    // Item kinds
    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_BLINK  = 1'b1;

    // Detections raised by one sample
    typedef struct packed {
        logic tilt;
        logic front;
        logic left;
        logic right;
    } hits_t;

endpackage

`default_nettype wire

// ===== rtl/ceha_detect.sv =====
// ---------------------------------------------------------------------------
// ceha_detect
// Switch voting and accelerometer magnitude check for one sample.
// ---------------------------------------------------------------------------
`default_nettype none

module ceha_detect #(
    parameter int unsigned VOTE_SAMPLES = 5
) (
    input  wire logic [VOTE_SAMPLES-1:0]       front_samples,
    input  wire logic [VOTE_SAMPLES-1:0]       left_samples,
    input  wire logic [VOTE_SAMPLES-1:0]       right_samples,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_x_first,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_y_first,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_x_second,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_y_second,
    input  wire logic [ceha_pkg::THR_W-1:0]    tilt_threshold,
    input  wire logic [ceha_pkg::VOTE_W-1:0]   vote_min,
    output ceha_pkg::hits_t                    hits
);
    import ceha_pkg::*;

    localparam int unsigned CNT_W = $clog2(VOTE_SAMPLES + 1);
    localparam int unsigned CMP_W = (CNT_W > VOTE_W) ? CNT_W : VOTE_W;

    function automatic logic voted(input logic [VOTE_SAMPLES-1:0] bits,
                                   input logic [VOTE_W-1:0] need);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < VOTE_SAMPLES; i++)
        begin
            cnt = cnt + CNT_W'(bits[i]);
        end
        return CMP_W'(cnt) >= CMP_W'(need);
    endfunction

    // -32768 yields 32768, which is above any 15-bit threshold
    function automatic logic over(input logic signed [ACCEL_W-1:0] a,
                                  input logic [THR_W-1:0] thr);
        logic signed [ACCEL_W:0] ext;
        logic [ACCEL_W:0]        mag;
        ext = {a[ACCEL_W-1], a};
        mag = a[ACCEL_W-1] ? (ACCEL_W+1)'(-ext) : (ACCEL_W+1)'(ext);
        return mag > (ACCEL_W+1)'(thr);
    endfunction

    always_comb
    begin
        hits.tilt  = over(accel_x_first, tilt_threshold)
                   | over(accel_y_first, tilt_threshold)
                   | over(accel_x_second, tilt_threshold)
                   | over(accel_y_second, tilt_threshold);
        hits.front = voted(front_samples, vote_min);
        hits.left  = voted(left_samples, vote_min);
        hits.right = voted(right_samples, vote_min);
    end

endmodule

`default_nettype wire

// ===== rtl/crash_event_hold_alarm_unit.sv =====
// ---------------------------------------------------------------------------
// crash_event_hold_alarm_unit
// Collision and tilt event hold with one-shot alert, buzzer and LED blink.
// ---------------------------------------------------------------------------
// Takes one item per clock when the output side keeps up. An accepted item is
// captured in an input register, evaluated against the event state when the
// result register is free and shown from the result register. Throughput
// is set by the single state update per cycle that every item makes (stamps,
// alert latch, buzzer level, blink phase); the input register takes one more
// item while a finished result waits to be taken, then holds off the input.
// Event stamps count only once their valid bit is set, so nothing is active
// after reset. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the unit is idle, which the unit itself
// does not enforce. An index beyond the register list is ignored.
`default_nettype none

`include "assert_macros.svh"

module crash_event_hold_alarm_unit #(
    parameter int unsigned VOTE_SAMPLES = 5
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_we,
    input  wire logic [ceha_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ceha_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                action,
    input  wire logic [ceha_pkg::HOLD_W-1:0]         now_ms,
    input  wire logic [VOTE_SAMPLES-1:0]             front_samples,
    input  wire logic [VOTE_SAMPLES-1:0]             left_samples,
    input  wire logic [VOTE_SAMPLES-1:0]             right_samples,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_x_first,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_y_first,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_x_second,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_y_second,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     tilt_active,
    output logic                                     front_active,
    output logic                                     left_active,
    output logic                                     right_active,
    output logic                                     all_safe,
    output logic                                     send_alert,
    output logic                                     buzzer_on,
    output logic                                     front_led,
    output logic                                     left_led,
    output logic                                     right_led
);
    import ceha_pkg::*;

    typedef struct packed {
        logic tilt_active;
        logic front_active;
        logic left_active;
        logic right_active;
        logic all_safe;
        logic send_alert;
        logic buzzer_on;
        logic front_led;
        logic left_led;
        logic right_led;
    } result_t;

    // Valid bit positions
    localparam int unsigned V_TILT   = 0;
    localparam int unsigned V_FRONT  = 1;
    localparam int unsigned V_LEFT   = 2;
    localparam int unsigned V_RIGHT  = 3;
    localparam int unsigned V_BUZZER = 4;
    localparam int unsigned NUM_V    = 5;

    // Configuration
    logic [HOLD_W-1:0] hold_ms_reg;
    logic [THR_W-1:0]  tilt_threshold_reg;
    logic [VOTE_W-1:0] vote_min_reg;

    // Input register
    logic                      s1_valid_reg;
    logic                      s1_action_reg;
    logic [HOLD_W-1:0]         s1_now_reg;
    logic [VOTE_SAMPLES-1:0]   s1_front_reg;
    logic [VOTE_SAMPLES-1:0]   s1_left_reg;
    logic [VOTE_SAMPLES-1:0]   s1_right_reg;
    logic signed [ACCEL_W-1:0] s1_ax1_reg;
    logic signed [ACCEL_W-1:0] s1_ay1_reg;
    logic signed [ACCEL_W-1:0] s1_ax2_reg;
    logic signed [ACCEL_W-1:0] s1_ay2_reg;

    // Event state
    logic [HOLD_W-1:0] tilt_stamp_reg,   tilt_stamp_next;
    logic [HOLD_W-1:0] front_stamp_reg,  front_stamp_next;
    logic [HOLD_W-1:0] left_stamp_reg,   left_stamp_next;
    logic [HOLD_W-1:0] right_stamp_reg,  right_stamp_next;
    logic [HOLD_W-1:0] buzzer_stamp_reg, buzzer_stamp_next;
    logic [NUM_V-1:0]  stamp_valid_reg,  stamp_valid_next;
    logic              alert_latched_reg, alert_latched_next;
    logic              blink_phase_reg,   blink_phase_next;
    logic              buzzer_reg,        buzzer_next;

    // Result register
    logic    out_valid_reg;
    result_t result_reg, result_next;

    hits_t hits;
    logic  advance;
    logic  fire;
    logic  take;
    logic  is_blink;
    logic  ta, fa, la, ra, safe;

    function automatic logic live(input logic valid, input logic [HOLD_W-1:0] stamp,
                                  input logic [HOLD_W-1:0] now,
                                  input logic [HOLD_W-1:0] hold);
        logic [HOLD_W-1:0] age;
        age = now - stamp;
        return valid && (age < hold);
    endfunction

    ceha_detect #(
        .VOTE_SAMPLES (VOTE_SAMPLES)
    ) u_detect (
        .front_samples  (s1_front_reg),
        .left_samples   (s1_left_reg),
        .right_samples  (s1_right_reg),
        .accel_x_first  (s1_ax1_reg),
        .accel_y_first  (s1_ay1_reg),
        .accel_x_second (s1_ax2_reg),
        .accel_y_second (s1_ay2_reg),
        .tilt_threshold (tilt_threshold_reg),
        .vote_min       (vote_min_reg),
        .hits           (hits)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign take     = in_valid && in_ready;
    assign is_blink = (s1_action_reg == ACTION_BLINK);

    always_comb
    begin
        tilt_stamp_next    = tilt_stamp_reg;
        front_stamp_next   = front_stamp_reg;
        left_stamp_next    = left_stamp_reg;
        right_stamp_next   = right_stamp_reg;
        buzzer_stamp_next  = buzzer_stamp_reg;
        stamp_valid_next   = stamp_valid_reg;
        alert_latched_next = alert_latched_reg;
        buzzer_next        = buzzer_reg;
        blink_phase_next   = blink_phase_reg ^ is_blink;
        result_next        = '0;

        if (!is_blink)
        begin
            if (hits.tilt)
            begin
                tilt_stamp_next          = s1_now_reg;
                stamp_valid_next[V_TILT] = 1'b1;
            end
            if (hits.front)
            begin
                front_stamp_next          = s1_now_reg;
                stamp_valid_next[V_FRONT] = 1'b1;
            end
            if (hits.left)
            begin
                left_stamp_next          = s1_now_reg;
                stamp_valid_next[V_LEFT] = 1'b1;
            end
            if (hits.right)
            begin
                right_stamp_next          = s1_now_reg;
                stamp_valid_next[V_RIGHT] = 1'b1;
            end
        end

        ta = live(stamp_valid_next[V_TILT],  tilt_stamp_next,  s1_now_reg, hold_ms_reg);
        fa = live(stamp_valid_next[V_FRONT], front_stamp_next, s1_now_reg, hold_ms_reg);
        la = live(stamp_valid_next[V_LEFT],  left_stamp_next,  s1_now_reg, hold_ms_reg);
        ra = live(stamp_valid_next[V_RIGHT], right_stamp_next, s1_now_reg, hold_ms_reg);
        safe = !(ta || fa || la || ra);

        if (!is_blink)
        begin
            // Clear the latch when calm; raise the alert on the first unsafe sample
            if (safe)
            begin
                alert_latched_next = 1'b0;
            end
            else if (!alert_latched_reg)
            begin
                buzzer_stamp_next          = s1_now_reg;
                stamp_valid_next[V_BUZZER] = 1'b1;
                alert_latched_next         = 1'b1;
                result_next.send_alert     = 1'b1;
            end
            buzzer_next = !safe && live(stamp_valid_next[V_BUZZER], buzzer_stamp_next,
                                        s1_now_reg, hold_ms_reg);
        end

        result_next.tilt_active  = ta;
        result_next.front_active = fa;
        result_next.left_active  = la;
        result_next.right_active = ra;
        result_next.all_safe     = safe;
        result_next.buzzer_on    = buzzer_next;
        result_next.front_led    = fa && blink_phase_next;
        result_next.left_led     = la && blink_phase_next;
        result_next.right_led    = ra && blink_phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg        <= HOLD_MS_RST;
            tilt_threshold_reg <= TILT_THRESHOLD_RST;
            vote_min_reg       <= VOTE_MIN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_HOLD_MS)
            begin
                hold_ms_reg <= cfg_data[HOLD_W-1:0];
            end
            if (cfg_index == REG_TILT_THRESHOLD)
            begin
                tilt_threshold_reg <= cfg_data[THR_W-1:0];
            end
            if (cfg_index == REG_VOTE_MIN)
            begin
                vote_min_reg <= cfg_data[VOTE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            tilt_stamp_reg    <= '0;
            front_stamp_reg   <= '0;
            left_stamp_reg    <= '0;
            right_stamp_reg   <= '0;
            buzzer_stamp_reg  <= '0;
            stamp_valid_reg   <= '0;
            alert_latched_reg <= 1'b0;
            blink_phase_reg   <= 1'b0;
            buzzer_reg        <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg     <= 1'b1;
                tilt_stamp_reg    <= tilt_stamp_next;
                front_stamp_reg   <= front_stamp_next;
                left_stamp_reg    <= left_stamp_next;
                right_stamp_reg   <= right_stamp_next;
                buzzer_stamp_reg  <= buzzer_stamp_next;
                stamp_valid_reg   <= stamp_valid_next;
                alert_latched_reg <= alert_latched_next;
                blink_phase_reg   <= blink_phase_next;
                buzzer_reg        <= buzzer_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_action_reg <= action;
            s1_now_reg    <= now_ms;
            s1_front_reg  <= front_samples;
            s1_left_reg   <= left_samples;
            s1_right_reg  <= right_samples;
            s1_ax1_reg    <= accel_x_first;
            s1_ay1_reg    <= accel_y_first;
            s1_ax2_reg    <= accel_x_second;
            s1_ay2_reg    <= accel_y_second;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tilt_active  = result_reg.tilt_active;
    assign front_active = result_reg.front_active;
    assign left_active  = result_reg.left_active;
    assign right_active = result_reg.right_active;
    assign all_safe     = result_reg.all_safe;
    assign send_alert   = result_reg.send_alert;
    assign buzzer_on    = result_reg.buzzer_on;
    assign front_led    = result_reg.front_led;
    assign left_led     = result_reg.left_led;
    assign right_led    = result_reg.right_led;

    `ASSERT_IMPLY(a_stall_only_when_full, !in_ready,
                  s1_valid_reg && out_valid_reg && !out_ready,
                  "input stalled while the pipeline can move")
    `ASSERT_IMPLY(a_alert_not_safe, out_valid_reg && result_reg.send_alert,
                  !result_reg.all_safe && alert_latched_reg,
                  "alert shown while safe or without the latch set")
    `ASSERT_IMPLY(a_led_needs_event,
                  out_valid_reg && (result_reg.front_led || result_reg.left_led
                                    || result_reg.right_led),
                  (!result_reg.front_led || result_reg.front_active)
                  && (!result_reg.left_led || result_reg.left_active)
                  && (!result_reg.right_led || result_reg.right_active),
                  "LED lit for an inactive collision")
    `ASSERT_NEXT(a_fire_shows_result, fire, out_valid_reg,
                 "evaluated item did not reach the result register")

endmodule

`default_nettype wire

// ===== bench/ceha_alarm_checker.sv =====
// ---------------------------------------------------------------------------
// ceha_alarm_checker
// Watches the configuration port and both item channels of the crash event
// hold alarm, predicts each result beat from its own copy of the event state,
// and compares every accepted result field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module ceha_alarm_checker #(
    parameter int unsigned VOTE_SAMPLES = 5
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_we,
    input  wire logic [ceha_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ceha_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic                                action,
    input  wire logic [ceha_pkg::HOLD_W-1:0]         now_ms,
    input  wire logic [VOTE_SAMPLES-1:0]             front_samples,
    input  wire logic [VOTE_SAMPLES-1:0]             left_samples,
    input  wire logic [VOTE_SAMPLES-1:0]             right_samples,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_x_first,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_y_first,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_x_second,
    input  wire logic signed [ceha_pkg::ACCEL_W-1:0] accel_y_second,

    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic                                tilt_active,
    input  wire logic                                front_active,
    input  wire logic                                left_active,
    input  wire logic                                right_active,
    input  wire logic                                all_safe,
    input  wire logic                                send_alert,
    input  wire logic                                buzzer_on,
    input  wire logic                                front_led,
    input  wire logic                                left_led,
    input  wire logic                                right_led,

    output int                                       mismatch_count,
    output int                                       pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ceha_pkg::*;

    localparam int EV_TILT  = 0;
    localparam int EV_FRONT = 1;
    localparam int EV_LEFT  = 2;
    localparam int EV_RIGHT = 3;
    localparam int EV_BUZZ  = 4;

    typedef struct packed {
        logic tilt_active;
        logic front_active;
        logic left_active;
        logic right_active;
        logic all_safe;
        logic send_alert;
        logic buzzer_on;
        logic front_led;
        logic left_led;
        logic right_led;
    } alarm_view_t;

    string view_names [10] = '{"tilt_active", "front_active", "left_active",
                               "right_active", "all_safe", "send_alert", "buzzer_on",
                               "front_led", "left_led", "right_led"};

    // predicted configuration and event state
    logic [HOLD_W-1:0] hold_win;
    logic [THR_W-1:0]  tilt_thr;
    logic [VOTE_W-1:0] vote_need;
    logic [31:0]       stamp [5];
    logic [4:0]        stamp_ok;
    logic              alert_held;
    logic              phase;
    logic              buzz_level;

    alarm_view_t alarm_expect_q [$];
    int          errs;
    int          n_results;

    function automatic logic switch_hit(input logic [VOTE_SAMPLES-1:0] bits);
        return $countones(bits) >= int'(vote_need);
    endfunction

    function automatic logic tilt_over(input logic signed [ACCEL_W-1:0] a);
        int mag;
        mag = a;
        if (mag < 0)
            mag = -mag;
        return mag > int'(tilt_thr);
    endfunction

    // an event counts only once stamped; age wraps modulo 2^32
    function automatic logic window_open(input int ev, input logic [31:0] now);
        logic [31:0] age;
        age = now - stamp[ev];
        return stamp_ok[ev] && (age < hold_win);
    endfunction

    function automatic alarm_view_t step_alarm(
        input logic                      act,
        input logic [31:0]               now,
        input logic [VOTE_SAMPLES-1:0]   fs,
        input logic [VOTE_SAMPLES-1:0]   ls,
        input logic [VOTE_SAMPLES-1:0]   rs,
        input logic signed [ACCEL_W-1:0] a0,
        input logic signed [ACCEL_W-1:0] a1,
        input logic signed [ACCEL_W-1:0] a2,
        input logic signed [ACCEL_W-1:0] a3
    );
        alarm_view_t v;
        logic        safe;
        v = '0;
        if (act == ACTION_BLINK) begin
            phase = ~phase;
        end
        else begin
            if (tilt_over(a0) || tilt_over(a1) || tilt_over(a2) || tilt_over(a3)) begin
                stamp[EV_TILT]    = now;
                stamp_ok[EV_TILT] = 1'b1;
            end
            if (switch_hit(fs)) begin
                stamp[EV_FRONT]    = now;
                stamp_ok[EV_FRONT] = 1'b1;
            end
            if (switch_hit(ls)) begin
                stamp[EV_LEFT]    = now;
                stamp_ok[EV_LEFT] = 1'b1;
            end
            if (switch_hit(rs)) begin
                stamp[EV_RIGHT]    = now;
                stamp_ok[EV_RIGHT] = 1'b1;
            end
        end

        v.tilt_active  = window_open(EV_TILT, now);
        v.front_active = window_open(EV_FRONT, now);
        v.left_active  = window_open(EV_LEFT, now);
        v.right_active = window_open(EV_RIGHT, now);
        safe = !(v.tilt_active || v.front_active || v.left_active || v.right_active);
        v.all_safe = safe;

        if (act == ACTION_SAMPLE) begin
            if (safe)
                alert_held = 1'b0;
            else if (!alert_held) begin
                stamp[EV_BUZZ]    = now;
                stamp_ok[EV_BUZZ] = 1'b1;
                alert_held        = 1'b1;
                v.send_alert      = 1'b1;
            end
            buzz_level = !safe && window_open(EV_BUZZ, now);
        end

        v.buzzer_on = buzz_level;
        v.front_led = v.front_active & phase;
        v.left_led  = v.left_active & phase;
        v.right_led = v.right_active & phase;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        alarm_view_t got;
        alarm_view_t want;
        if (!rst_n) begin
            hold_win   = HOLD_MS_RST;
            tilt_thr   = TILT_THRESHOLD_RST;
            vote_need  = VOTE_MIN_RST;
            for (int e = 0; e < 5; e++)
                stamp[e] = '0;
            stamp_ok   = '0;
            alert_held = 1'b0;
            phase      = 1'b0;
            buzz_level = 1'b0;
            alarm_expect_q.delete();
            errs       = 0;
            n_results  = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_HOLD_MS:        hold_win  = cfg_data[HOLD_W-1:0];
                    REG_TILT_THRESHOLD: tilt_thr  = cfg_data[THR_W-1:0];
                    REG_VOTE_MIN:       vote_need = cfg_data[VOTE_W-1:0];
                    default:            ;
                endcase
            end

            if (out_valid && out_ready) begin
                got = '{tilt_active, front_active, left_active, right_active, all_safe,
                        send_alert, buzzer_on, front_led, left_led, right_led};
                if (alarm_expect_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result beat %0d: %b", n_results, got);
                end
                else begin
                    want = alarm_expect_q.pop_front();
                    for (int k = 0; k < 10; k++) begin
                        if (got[9-k] !== want[9-k]) begin
                            errs++;
                            if (errs <= 10)
                                $display("result beat %0d %s: expected %b, got %b",
                                         n_results, view_names[k], want[9-k], got[9-k]);
                        end
                    end
                end
                n_results++;
            end

            if (in_valid && in_ready)
                alarm_expect_q.push_back(step_alarm(action, now_ms, front_samples,
                    left_samples, right_samples, accel_x_first, accel_y_first,
                    accel_x_second, accel_y_second));

            mismatch_count <= errs;
            pending_count  <= alarm_expect_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_crash_event_hold_alarm_unit.sv =====
// ---------------------------------------------------------------------------
// tb_crash_event_hold_alarm_unit
// Drives sensor samples and blink ticks into the crash event hold alarm under
// a series of register settings: a directed run through boot, voting, tilt
// thresholds, hold expiry, time wrap and the zero and out-of-range settings,
// then random event sequences with random stalls on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_crash_event_hold_alarm_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ceha_pkg::*;

    localparam int  VOTE_SAMPLES = 5;
    localparam time PERIOD       = 20;
    localparam int  PHASE_ITEMS  = 160;

    typedef struct {
        logic                      action;
        logic [31:0]               now;
        logic [VOTE_SAMPLES-1:0]   fs;
        logic [VOTE_SAMPLES-1:0]   ls;
        logic [VOTE_SAMPLES-1:0]   rs;
        logic signed [ACCEL_W-1:0] ax1;
        logic signed [ACCEL_W-1:0] ay1;
        logic signed [ACCEL_W-1:0] ax2;
        logic signed [ACCEL_W-1:0] ay2;
    } reading_t;

    logic                      clk   = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_HOLD_MS;
    logic [CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic                      action    = ACTION_SAMPLE;
    logic [HOLD_W-1:0]         now_ms    = '0;
    logic [VOTE_SAMPLES-1:0]   front_samples  = '0;
    logic [VOTE_SAMPLES-1:0]   left_samples   = '0;
    logic [VOTE_SAMPLES-1:0]   right_samples  = '0;
    logic signed [ACCEL_W-1:0] accel_x_first  = '0;
    logic signed [ACCEL_W-1:0] accel_y_first  = '0;
    logic signed [ACCEL_W-1:0] accel_x_second = '0;
    logic signed [ACCEL_W-1:0] accel_y_second = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      tilt_active, front_active, left_active, right_active;
    logic                      all_safe, send_alert, buzzer_on;
    logic                      front_led, left_led, right_led;
    int                        mismatch_count;
    int                        pending_count;

    logic                      calm = 1'b0;
    logic [HOLD_W-1:0]         cur_hold = HOLD_MS_RST;
    logic [THR_W-1:0]          cur_thr  = TILT_THRESHOLD_RST;
    logic [31:0]               clock_ms = '0;

    crash_event_hold_alarm_unit #(.VOTE_SAMPLES(VOTE_SAMPLES)) uut (.*);

    ceha_alarm_checker #(.VOTE_SAMPLES(VOTE_SAMPLES)) alarm_check (.*);

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 8);

    function automatic logic sender_pause();
        return !calm && ($urandom_range(0, 99) < 8);
    endfunction

    // hold the beat until accepted; payload stays put while valid is high
    task automatic send_reading(input reading_t r);
        while (sender_pause()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= r.action;
        now_ms         <= r.now;
        front_samples  <= r.fs;
        left_samples   <= r.ls;
        right_samples  <= r.rs;
        accel_x_first  <= r.ax1;
        accel_y_first  <= r.ay1;
        accel_x_second <= r.ax2;
        accel_y_second <= r.ay2;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_sample(
        input logic [31:0]               now,
        input logic [VOTE_SAMPLES-1:0]   fs,
        input logic [VOTE_SAMPLES-1:0]   ls,
        input logic [VOTE_SAMPLES-1:0]   rs,
        input logic signed [ACCEL_W-1:0] ax1,
        input logic signed [ACCEL_W-1:0] ay1,
        input logic signed [ACCEL_W-1:0] ax2,
        input logic signed [ACCEL_W-1:0] ay2
    );
        reading_t r;
        r = '{ACTION_SAMPLE, now, fs, ls, rs, ax1, ay1, ax2, ay2};
        send_reading(r);
    endtask

    task automatic send_blink(input logic [31:0] now);
        reading_t r;
        r = '{ACTION_BLINK, now, '0, '0, '0, '0, '0, '0, '0};
        send_reading(r);
    endtask

    // drain every outstanding result, then cover the input and result registers
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_HOLD_MS:        cur_hold = data;
            REG_TILT_THRESHOLD: cur_thr  = data[THR_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] hold, input logic [31:0] thr,
                           input logic [31:0] vote);
        set_register(REG_HOLD_MS, hold);
        set_register(REG_TILT_THRESHOLD, thr);
        set_register(REG_VOTE_MIN, vote);
    endtask

    // mostly at or below threshold, some within one of it, the rest anywhere
    function automatic logic signed [ACCEL_W-1:0] pick_accel(input logic quiet);
        int pick;
        int mag;
        pick = $urandom_range(0, 9);
        if (quiet || pick < 5)
            mag = $urandom_range(0, int'(cur_thr));
        else if (pick < 7)
            mag = int'(cur_thr) - 1 + $urandom_range(0, 2);
        else
            return ACCEL_W'($urandom);
        if (mag < 0)
            mag = 0;
        if ($urandom_range(0, 1))
            mag = -mag;
        return ACCEL_W'(mag);
    endfunction

    function automatic logic [VOTE_SAMPLES-1:0] pick_switch(input logic quiet);
        if (quiet || $urandom_range(0, 9) < 6)
            return '0;
        return VOTE_SAMPLES'($urandom);
    endfunction

    task automatic random_reading(output reading_t r);
        logic [31:0] step_max;
        logic        quiet;
        step_max = (cur_hold > 32'h0FFF_FFFF) ? 32'h0FFF_FFFF : cur_hold / 3 + 3;
        if ($urandom_range(0, 99) < 5)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, step_max);
        quiet    = $urandom_range(0, 99) < 40;
        r.action = ($urandom_range(0, 99) < 20) ? ACTION_BLINK : ACTION_SAMPLE;
        r.now    = clock_ms;
        r.fs     = pick_switch(quiet);
        r.ls     = pick_switch(quiet);
        r.rs     = pick_switch(quiet);
        r.ax1    = pick_accel(quiet);
        r.ay1    = pick_accel(quiet);
        r.ax2    = pick_accel(quiet);
        r.ay2    = pick_accel(quiet);
    endtask

    initial begin
        reading_t    r;
        logic [31:0] hold_set [8];
        logic [31:0] thr_set  [8];
        logic [31:0] vote_set [8];

        hold_set = '{32'd10000, 32'd1, 32'd50, 32'hFFFF_FFFF, 32'd300, 32'd0, 32'd0, 32'd0};
        thr_set  = '{32'd9830, 32'd0, 32'd32767, 32'd16384, 32'd1000, 32'd5, 32'd0, 32'd0};
        vote_set = '{32'd3, 32'd1, 32'd5, 32'd0, 32'd6, 32'd4, 32'd0, 32'd0};
        for (int p = 6; p < 8; p++) begin
            hold_set[p] = $urandom_range(1, 5000);
            thr_set[p]  = $urandom_range(0, 32767);
            vote_set[p] = $urandom_range(0, 7);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boot: zero stamps must not alarm
        send_sample(32'd5, 5'b00000, 5'b00000, 5'b00000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_blink(32'd10);
        send_sample(32'd100, 5'b00111, 5'b00000, 5'b00000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(32'd200, 5'b00011, 5'b01011, 5'b00000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_blink(32'd250);
        send_blink(32'd260);
        // right at threshold is not tilt, one above is
        send_sample(32'd300, 5'b00000, 5'b00000, 5'b11111, 16'sd9830, -16'sd9830,
                    16'sd0, 16'sd0);
        send_sample(32'd400, 5'b00000, 5'b00000, 5'b00000, 16'sd0, 16'sd0,
                    16'sd9831, 16'sd0);
        send_sample(32'd500, 5'b00000, 5'b00000, 5'b00000, 16'sd0, 16'sd0,
                    16'sd0, -16'sd32768);
        send_sample(32'd600, 5'b00000, 5'b00000, 5'b00000, 16'sd32767, 16'sd0,
                    16'sd0, -16'sd9831);
        // front expires between these two
        send_sample(32'd10099, 5'b00000, 5'b00000, 5'b00000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(32'd10100, 5'b00000, 5'b00000, 5'b00000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        // everything expired: latch clears, buzzer drops
        send_sample(32'd20000, 5'b00000, 5'b00000, 5'b00000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_blink(32'd20001);
        send_sample(32'd20002, 5'b00000, 5'b00000, 5'b10101, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        // wrap the clock with an event held across it
        send_sample(32'hFFFF_FFF0, 5'b00000, 5'b11100, 5'b00000, 16'sd0, 16'sd0,
                    16'sd0, 16'sd0);
        send_sample(32'h0000_0100, 5'b00000, 5'b00000, 5'b00000, 16'sd0, 16'sd0,
                    16'sd0, 16'sd0);
        send_sample(32'hFFFF_FFFF, 5'b11111, 5'b11111, 5'b11111, -16'sd1, 16'sd1,
                    -16'sd32768, 16'sd32767);
        settle();

        // zero hold and zero vote: every switch hits yet nothing is active
        set_all(32'd0, 32'd0, 32'd0);
        send_sample(32'd7000, 5'b00000, 5'b00000, 5'b00000, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
        settle();
        // vote above the sample count never hits; old stamps still age
        set_all(32'd1, 32'd0, 32'd7);
        send_sample(32'd7000, 5'b11111, 5'b11111, 5'b11111, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(32'd7001, 5'b11111, 5'b11111, 5'b11111, 16'sd0, 16'sd0, 16'sd0, -16'sd1);
        send_sample(32'd7002, 5'b11111, 5'b11111, 5'b11111, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        settle();

        clock_ms = 32'd8000;
        for (int p = 0; p < 8; p++) begin
            set_all(hold_set[p], thr_set[p], vote_set[p]);
            calm <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_reading(r);
                send_reading(r);
            end
            settle();
        end

        if (mismatch_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/ceha_pkg.sv
rtl/ceha_detect.sv
rtl/crash_event_hold_alarm_unit.sv
bench/ceha_alarm_checker.sv
bench/tb_crash_event_hold_alarm_unit.sv
